### rtl/pfr_pkg.sv
// shared types and constants of the page frame replacement unit
package pfr_pkg;

  localparam int unsigned DEF_MAX_FRAMES = 16;
  localparam int unsigned DEF_PAGE_BITS  = 16;

  localparam int unsigned STAMP_W    = 32;
  localparam int unsigned FAULT_W    = 32;
  localparam int unsigned FIDX_W     = 4;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 5;

  localparam logic [CFG_DATA_W-1:0] FRAMES_RESET = 5'd16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLICY_MODE   = 1'b0,
    CFG_FRAMES_IN_USE = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_WRITE
  } pfr_state_e;

endpackage

### rtl/pfr_if.sv
// reference and result channels of the page frame replacement unit
interface pfr_in_if #(
  parameter int unsigned PAGE_BITS = pfr_pkg::DEF_PAGE_BITS
);
  logic                 valid;
  logic                 ready;
  logic [PAGE_BITS-1:0] page_number;
  logic                 first_in_string;

  modport source (output valid, output page_number, output first_in_string, input ready);
  modport sink   (input valid, input page_number, input first_in_string, output ready);
endinterface

interface pfr_out_if;
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic [pfr_pkg::FIDX_W-1:0]   frame_index;
  logic [pfr_pkg::FAULT_W-1:0]  fault_total;

  modport source (output valid, output hit, output frame_index, output fault_total,
                  input ready);
  modport sink   (input valid, input hit, input frame_index, input fault_total,
                  output ready);
endinterface

### rtl/pfr_frame_ram.sv
// frame table memory: one write port, one registered read port
module pfr_frame_ram #(
  parameter int unsigned DEPTH = pfr_pkg::DEF_MAX_FRAMES,
  parameter int unsigned WIDTH = pfr_pkg::DEF_PAGE_BITS + pfr_pkg::STAMP_W,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

### rtl/page_frame_replacement_unit.sv
// top level of the page frame replacement unit (fifo / lru)
//
// usage:
// - in_i carries one page reference per word: page_number and first_in_string.
//   first_in_string clears all frames, the access clock and the fault count
//   before that reference is handled
// - out_o returns one word per reference: hit, frame_index, fault_total
// - cfg_we_i / cfg_idx_i / cfg_data_i write policy_mode (index 0) and
//   frames_in_use (index 1); write only while no reference is in flight
// - page and stamp of each frame live in a small memory; frames are scanned
//   one per cycle through its read port, with valid bits kept in flops
// - a reference goes from acceptance through one read of the frame memory per
//   active frame (1..MAX_FRAMES), a wait for the last read to return, then one
//   write-back and result step;
//   the next reference is taken in the cycle after write-back
// - the result register lets a new reference be accepted and scanned while
//   the previous word waits; write-back waits until that word is taken
// - reset clears valid bits, clock, fault count, sets fifo and 16 frames;
//   no memory clearing pass is needed
module page_frame_replacement_unit #(
  parameter int unsigned MAX_FRAMES = pfr_pkg::DEF_MAX_FRAMES,
  parameter int unsigned PAGE_BITS  = pfr_pkg::DEF_PAGE_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pfr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [pfr_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  pfr_in_if.sink                           in_i,
  pfr_out_if.source                        out_o
);

  localparam int unsigned IDX_W   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned CNT_W   = $clog2(MAX_FRAMES + 1);
  localparam int unsigned STAMP_W = pfr_pkg::STAMP_W;
  localparam int unsigned ENT_W   = PAGE_BITS + STAMP_W;

  // control state
  pfr_pkg::pfr_state_e state_q, state_d;
  logic [IDX_W-1:0]            scan_q, scan_d;
  logic                        chk_q, chk_d;
  logic [IDX_W-1:0]            chkidx_q, chkidx_d;
  logic [MAX_FRAMES-1:0]       valid_q, valid_d;
  logic [STAMP_W-1:0]          clock_q, clock_d;
  logic [pfr_pkg::FAULT_W-1:0] fault_q, fault_d;
  logic                        policy_q, policy_d;
  logic [pfr_pkg::CFG_DATA_W-1:0] frames_q, frames_d;
  logic                        outv_q, outv_d;

  // payload
  logic [PAGE_BITS-1:0]        page_q, page_d;
  logic                        hitf_q, hitf_d;
  logic [IDX_W-1:0]            hitidx_q, hitidx_d;
  logic [STAMP_W-1:0]          oldstamp_q, oldstamp_d;
  logic [IDX_W-1:0]            oldidx_q, oldidx_d;
  logic                        ohit_q, ohit_d;
  logic [pfr_pkg::FIDX_W-1:0]  oidx_q, oidx_d;
  logic [pfr_pkg::FAULT_W-1:0] otot_q, otot_d;

  logic                 acc;
  logic                 scan_last;
  logic                 wr_go;
  logic                 rd_en;
  logic                 wr_en;
  logic [ENT_W-1:0]     rd_data;
  logic [PAGE_BITS-1:0] rd_page;
  logic [STAMP_W-1:0]   rd_stamp;
  logic [CNT_W-1:0]     n_act;
  logic                 empty_found;
  logic [IDX_W-1:0]     empty_idx;
  logic [IDX_W-1:0]     slot;
  logic [pfr_pkg::FAULT_W-1:0] fault_nx;

  // active frame count, clamped into 1..MAX_FRAMES
  always_comb begin
    if (frames_q == '0) begin
      n_act = CNT_W'(1);
    end else if (32'(frames_q) > MAX_FRAMES) begin
      n_act = CNT_W'(MAX_FRAMES);
    end else begin
      n_act = CNT_W'(frames_q);
    end
  end

  // lowest empty frame among the active ones
  always_comb begin
    empty_found = 1'b0;
    empty_idx   = '0;
    for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
      if ((32'(i) < 32'(n_act)) && !valid_q[i]) begin
        empty_found = 1'b1;
        empty_idx   = IDX_W'(i);
      end
    end
  end

  assign acc       = in_i.valid && in_i.ready;
  assign scan_last = (scan_q == IDX_W'(n_act - CNT_W'(1)));
  assign rd_page   = rd_data[ENT_W-1:STAMP_W];
  assign rd_stamp  = rd_data[STAMP_W-1:0];
  assign fault_nx  = (fault_q == '1) ? fault_q : fault_q + 1'b1;

  // victim: hit frame, else lowest empty, else oldest stamp
  always_comb begin
    if (hitf_q) begin
      slot = hitidx_q;
    end else if (empty_found) begin
      slot = empty_idx;
    end else begin
      slot = oldidx_q;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pfr_pkg::ST_IDLE:  if (acc) state_d = pfr_pkg::ST_SCAN;
      pfr_pkg::ST_SCAN:  if (scan_last) state_d = pfr_pkg::ST_LAST;
      pfr_pkg::ST_LAST:  state_d = pfr_pkg::ST_WRITE;
      pfr_pkg::ST_WRITE: if (wr_go) state_d = pfr_pkg::ST_IDLE;
      default:           state_d = pfr_pkg::ST_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_i.ready = 1'b0;
    rd_en      = 1'b0;
    wr_go      = 1'b0;
    case (state_q)
      pfr_pkg::ST_IDLE:  in_i.ready = 1'b1;
      pfr_pkg::ST_SCAN:  rd_en = 1'b1;
      pfr_pkg::ST_LAST:  ;
      pfr_pkg::ST_WRITE: wr_go = !outv_q || out_o.ready;
      default:           ;
    endcase
  end

  // fifo hits leave the table alone, lru hits refresh the stamp
  assign wr_en = wr_go && (!hitf_q || policy_q);

  pfr_frame_ram #(
    .DEPTH (MAX_FRAMES),
    .WIDTH (ENT_W),
    .AW    (IDX_W)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (slot),
    .wr_data_i ({page_q, clock_q}),
    .rd_en_i   (rd_en),
    .rd_addr_i (scan_q),
    .rd_data_o (rd_data)
  );

  // datapath
  always_comb begin
    scan_d     = scan_q;
    chk_d      = (state_q == pfr_pkg::ST_SCAN);
    chkidx_d   = scan_q;
    valid_d    = valid_q;
    clock_d    = clock_q;
    fault_d    = fault_q;
    policy_d   = policy_q;
    frames_d   = frames_q;
    outv_d     = outv_q;
    page_d     = page_q;
    hitf_d     = hitf_q;
    hitidx_d   = hitidx_q;
    oldstamp_d = oldstamp_q;
    oldidx_d   = oldidx_q;
    ohit_d     = ohit_q;
    oidx_d     = oidx_q;
    otot_d     = otot_q;

    if (acc) begin
      page_d = in_i.page_number;
      hitf_d = 1'b0;
      scan_d = '0;
      if (in_i.first_in_string) begin
        valid_d = '0;
        clock_d = '0;
        fault_d = '0;
      end
    end

    if (state_q == pfr_pkg::ST_SCAN) begin
      scan_d = scan_last ? '0 : scan_q + 1'b1;
    end

    // one frame comes back from memory per cycle
    if (chk_q) begin
      if (!hitf_q && valid_q[chkidx_q] && (rd_page == page_q)) begin
        hitf_d   = 1'b1;
        hitidx_d = chkidx_q;
      end
      if ((chkidx_q == '0) || (rd_stamp < oldstamp_q)) begin
        oldstamp_d = rd_stamp;
        oldidx_d   = chkidx_q;
      end
    end

    if (wr_go) begin
      if (!hitf_q) begin
        valid_d[slot] = 1'b1;
        fault_d       = fault_nx;
      end
      clock_d = (clock_q == '1) ? clock_q : clock_q + 1'b1;
      outv_d  = 1'b1;
      ohit_d  = hitf_q;
      oidx_d  = pfr_pkg::FIDX_W'(slot);
      otot_d  = hitf_q ? fault_q : fault_nx;
    end else if (out_o.ready) begin
      outv_d = 1'b0;
    end

    if (cfg_we_i) begin
      case (cfg_idx_i)
        pfr_pkg::CFG_POLICY_MODE:   policy_d = cfg_data_i[0];
        pfr_pkg::CFG_FRAMES_IN_USE: frames_d = cfg_data_i;
        default:                    ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= pfr_pkg::ST_IDLE;
      scan_q   <= '0;
      chk_q    <= 1'b0;
      chkidx_q <= '0;
      valid_q  <= '0;
      clock_q  <= '0;
      fault_q  <= '0;
      policy_q <= 1'b0;
      frames_q <= pfr_pkg::FRAMES_RESET;
      outv_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      scan_q   <= scan_d;
      chk_q    <= chk_d;
      chkidx_q <= chkidx_d;
      valid_q  <= valid_d;
      clock_q  <= clock_d;
      fault_q  <= fault_d;
      policy_q <= policy_d;
      frames_q <= frames_d;
      outv_q   <= outv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q     <= page_d;
    hitf_q     <= hitf_d;
    hitidx_q   <= hitidx_d;
    oldstamp_q <= oldstamp_d;
    oldidx_q   <= oldidx_d;
    ohit_q     <= ohit_d;
    oidx_q     <= oidx_d;
    otot_q     <= otot_d;
  end

  assign out_o.valid       = outv_q;
  assign out_o.hit         = ohit_q;
  assign out_o.frame_index = oidx_q;
  assign out_o.fault_total = otot_q;

  // scan address stays inside the active frames
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pfr_pkg::ST_SCAN) |-> (32'(scan_q) < 32'(n_act)))
    else $error("frame scan beyond active frame count");

  // an accepted reference starts a scan
  a_acc_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> (state_q == pfr_pkg::ST_SCAN))
    else $error("accepted reference did not start a scan");

  // a fault loads its frame as valid
  a_fault_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_go && !hitf_q) |=> valid_q[$past(slot)])
    else $error("faulted frame not marked valid");

  // a fault below saturation bumps the count by one
  a_fault_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_go && !hitf_q && (fault_q != '1)) |=> (fault_q == $past(fault_q) + 1'b1))
    else $error("fault count not advanced on a fault");

endmodule
